FILE: rtl/core/spom_pkg.sv
// shared types, widths and codes for the sweep-and-prune occlusion marker
// no dependencies

package spom_pkg;

	localparam int ACTIVE_DEPTH_DEF = 64;
	localparam int COORD_LIMIT_DEF  = 16384;

	localparam int ID_W        = 16;
	localparam int Y_W         = 14;
	localparam int DEPTH_W     = 24;
	localparam int QUEUE_DEPTH = 4;
	localparam int S_TDATA_W   = 88;
	localparam int M_TDATA_W   = 24;
	localparam int S_TUSER_W   = 2;

	typedef enum logic [1:0] {
		KIND_EDGE_IN  = 2'd0,
		KIND_EDGE_OUT = 2'd1,
		KIND_POINT    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_SEARCH,
		ST_READ_LAST,
		ST_COPY,
		ST_EMIT
	} back_state_t;

	// classified command handed from front to back
	typedef struct packed {
		kind_t                     op;
		logic [ID_W-1:0]           id;
		logic [Y_W-1:0]            top;
		logic [Y_W-1:0]            bottom;
		logic [Y_W-1:0]            cy;
		logic signed [DEPTH_W-1:0] depth;
	} cmd_t;

	// one active-set entry
	typedef struct packed {
		logic [ID_W-1:0]           id;
		logic [Y_W-1:0]            top;
		logic [Y_W-1:0]            bottom;
		logic signed [DEPTH_W-1:0] depth;
		logic                      marked;
	} entry_t;

	typedef struct packed {
		logic            kind;
		logic [ID_W-1:0] id;
		logic            hit;
		logic            error;
		logic            overflow;
	} res_t;

endpackage

FILE: rtl/core/spom_front.sv
// front end: input transaction capture, kind decode and y saturation
// depends on spom_pkg

module spom_front #(
	parameter int COORD_LIMIT = spom_pkg::COORD_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spom_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [spom_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            cmd_vld,
	output spom_pkg::cmd_t                  cmd,
	input  logic                            cmd_rdy
);

	localparam int YW = spom_pkg::Y_W;
	localparam int IW = spom_pkg::ID_W;
	localparam int DW = spom_pkg::DEPTH_W;
	localparam logic [YW-1:0] Y_SAT = YW'(COORD_LIMIT - 1);

	logic           vld_s1;
	spom_pkg::cmd_t cmd_s1;
	spom_pkg::cmd_t dec;
	logic           keep;
	logic           accept;

	function automatic logic [YW-1:0] sat_y(input logic [YW-1:0] y);
		if (32'(y) >= 32'(COORD_LIMIT))
			return Y_SAT;
		return y;
	endfunction

	always_comb begin
		dec.op     = spom_pkg::kind_t'(s_tuser);
		dec.id     = s_tdata[IW-1:0];
		dec.top    = sat_y(s_tdata[IW+YW-1:IW]);
		dec.bottom = sat_y(s_tdata[IW+2*YW-1:IW+YW]);
		dec.cy     = sat_y(s_tdata[IW+3*YW-1:IW+2*YW]);
		dec.depth  = $signed(s_tdata[IW+3*YW+DW-1:IW+3*YW]);
		case (s_tuser)
			spom_pkg::KIND_EDGE_IN,
			spom_pkg::KIND_EDGE_OUT,
			spom_pkg::KIND_POINT: keep = 1'b1;
			default:              keep = 1'b0;
		endcase
	end

	assign s_tready = !vld_s1 || cmd_rdy;
	assign accept   = s_tvalid && s_tready;
	assign cmd_vld  = vld_s1;
	assign cmd      = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			// unused kind codes are dropped here
			vld_s1 <= accept && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

FILE: rtl/core/spom_queue.sv
// short command fifo between front and back
// depends on spom_pkg

module spom_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  spom_pkg::cmd_t push_data,
	output logic           not_full,
	input  logic           pop,
	output logic           not_empty,
	output spom_pkg::cmd_t pop_data
);

	localparam int QD  = spom_pkg::QUEUE_DEPTH;
	localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
	localparam int QCW = $clog2(QD + 1);

	spom_pkg::cmd_t   slots_q [QD];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   fill_q;
	logic             do_push;
	logic             do_pop;

	assign not_full  = fill_q != QCW'(QD);
	assign not_empty = fill_q != '0;
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = slots_q[rd_ptr_q];

	function automatic logic [QAW-1:0] bump(input logic [QAW-1:0] p);
		if (p == QAW'(QD - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push)
				fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slots_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: rtl/core/spom_back.sv
// back end: active-set memory, insert, probe walk and swap-remove sequencer
// depends on spom_pkg

module spom_back #(
	parameter int ACTIVE_DEPTH = spom_pkg::ACTIVE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_vld,
	input  spom_pkg::cmd_t q_cmd,
	output logic           q_pop,
	output logic           res_vld,
	output spom_pkg::res_t res,
	input  logic           res_rdy
);

	localparam int AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
	localparam int CW = $clog2(ACTIVE_DEPTH + 1);

	spom_pkg::entry_t      mem [ACTIVE_DEPTH];

	spom_pkg::back_state_t state_q, state_nxt;
	logic [CW-1:0]         count_q;
	logic                  ovf_q;
	logic [CW-1:0]         walk_q;
	logic [CW-1:0]         walk_m1;
	logic [CW-1:0]         last;
	spom_pkg::cmd_t        cmd_q;
	logic [AW-1:0]         slot_q;
	logic                  hit_q;
	logic                  err_q;
	logic                  out_vld_q;
	spom_pkg::res_t        out_q;

	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	spom_pkg::entry_t      rd_data_s1;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_idx_s1;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	spom_pkg::entry_t      wr_data;
	logic                  out_free;
	logic                  out_load;
	logic                  set_full;
	logic                  probe_match;
	logic                  search_match;
	spom_pkg::entry_t      new_entry;
	spom_pkg::entry_t      marked_entry;

	assign set_full = count_q == CW'(ACTIVE_DEPTH);
	assign walk_m1  = walk_q - 1'b1;
	assign last     = count_q - 1'b1;
	assign out_free = !out_vld_q || res_rdy;

	assign probe_match = rd_vld_s1
		&& (cmd_q.cy >= rd_data_s1.top) && (cmd_q.cy <= rd_data_s1.bottom)
		&& ($signed(cmd_q.depth) >= $signed(rd_data_s1.depth));
	assign search_match = rd_vld_s1 && (rd_data_s1.id == cmd_q.id);

	always_comb begin
		new_entry.id     = q_cmd.id;
		new_entry.top    = q_cmd.top;
		new_entry.bottom = q_cmd.bottom;
		new_entry.depth  = q_cmd.depth;
		new_entry.marked = 1'b0;
		marked_entry        = rd_data_s1;
		marked_entry.marked = 1'b1;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			spom_pkg::ST_IDLE: begin
				if (q_vld) begin
					case (q_cmd.op)
						spom_pkg::KIND_EDGE_OUT: state_nxt = spom_pkg::ST_SEARCH;
						spom_pkg::KIND_POINT:    state_nxt = spom_pkg::ST_PROBE;
						default:                 state_nxt = spom_pkg::ST_IDLE;
					endcase
				end
			end
			spom_pkg::ST_PROBE: begin
				if (walk_q == count_q && !rd_vld_s1)
					state_nxt = spom_pkg::ST_EMIT;
			end
			spom_pkg::ST_SEARCH: begin
				if (search_match)
					state_nxt = spom_pkg::ST_READ_LAST;
				else if (walk_q == '0 && !rd_vld_s1)
					state_nxt = spom_pkg::ST_EMIT;
			end
			spom_pkg::ST_READ_LAST: state_nxt = spom_pkg::ST_COPY;
			spom_pkg::ST_COPY:      state_nxt = spom_pkg::ST_EMIT;
			spom_pkg::ST_EMIT: begin
				if (out_free)
					state_nxt = spom_pkg::ST_IDLE;
			end
			default: state_nxt = spom_pkg::ST_IDLE;
		endcase
	end

	// memory port and handshake controls
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = '0;
		wr_en    = 1'b0;
		wr_addr  = '0;
		wr_data  = new_entry;
		q_pop    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			spom_pkg::ST_IDLE: begin
				q_pop = q_vld;
				if (q_vld && q_cmd.op == spom_pkg::KIND_EDGE_IN && !set_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
				end
			end
			spom_pkg::ST_PROBE: begin
				rd_en   = walk_q != count_q;
				rd_addr = walk_q[AW-1:0];
				if (probe_match) begin
					wr_en   = 1'b1;
					wr_addr = rd_idx_s1;
					wr_data = marked_entry;
				end
			end
			spom_pkg::ST_SEARCH: begin
				// walk downward so the highest matching index wins
				rd_en   = walk_q != '0 && !search_match;
				rd_addr = walk_m1[AW-1:0];
			end
			spom_pkg::ST_READ_LAST: begin
				rd_en   = 1'b1;
				rd_addr = last[AW-1:0];
			end
			spom_pkg::ST_COPY: begin
				wr_en   = 1'b1;
				wr_addr = slot_q;
				wr_data = rd_data_s1;
			end
			spom_pkg::ST_EMIT: begin
				out_load = out_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spom_pkg::ST_IDLE;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_nxt;
			rd_vld_s1 <= rd_en;
			if (state_q == spom_pkg::ST_IDLE && q_vld && q_cmd.op == spom_pkg::KIND_EDGE_IN) begin
				if (set_full)
					ovf_q <= 1'b1;
				else
					count_q <= count_q + 1'b1;
			end
			if (state_q == spom_pkg::ST_COPY)
				count_q <= last;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (res_rdy)
				out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		case (state_q)
			spom_pkg::ST_IDLE: begin
				if (q_vld) begin
					cmd_q  <= q_cmd;
					walk_q <= (q_cmd.op == spom_pkg::KIND_EDGE_OUT) ? count_q : '0;
					hit_q  <= 1'b0;
					err_q  <= 1'b0;
				end
			end
			spom_pkg::ST_PROBE: begin
				if (rd_en)
					walk_q <= walk_q + 1'b1;
				if (probe_match)
					hit_q <= 1'b1;
			end
			spom_pkg::ST_SEARCH: begin
				if (rd_en)
					walk_q <= walk_m1;
				if (search_match) begin
					slot_q <= rd_idx_s1;
					hit_q  <= rd_data_s1.marked;
				end else if (walk_q == '0 && !rd_vld_s1) begin
					err_q <= 1'b1;
				end
			end
			default: begin
				hit_q <= hit_q;
			end
		endcase
		if (out_load) begin
			out_q.kind     <= cmd_q.op == spom_pkg::KIND_POINT;
			out_q.id       <= cmd_q.id;
			out_q.hit      <= hit_q;
			out_q.error    <= err_q;
			out_q.overflow <= ovf_q;
		end
	end

	assign res_vld = out_vld_q;
	assign res     = out_q;

endmodule

FILE: rtl/core/sweep_prune_occlusion_marker_unit.sv
// top level of the sweep-and-prune occlusion marker
// depends on spom_pkg, spom_front, spom_queue, spom_back
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata: id, y_low, y_high, caster_y, depth; s_tuser: kind
//  m_*      out  m_tvalid/m_tready  m_tdata: result_id, hit, error, overflow_seen;
//                                   m_tuser: result_kind
//
// a left edge is written from the idle state; a caster point walks every live entry and a right
// edge walks down from the last entry until a match, through the
// single read port of the active-set memory walked one entry a cycle
// a four-deep command queue lets the front keep taking transactions while the back walks
// reset clears the entry count, overflow flag, queue and valids; set contents are not cleared
// a stalled result holds in the output register and the back waits only when it must emit

module sweep_prune_occlusion_marker_unit #(
	parameter int ACTIVE_DEPTH = spom_pkg::ACTIVE_DEPTH_DEF,
	parameter int COORD_LIMIT  = spom_pkg::COORD_LIMIT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// id[15:0], y_low[29:16], y_high[43:30], caster_y[57:44], depth[81:58], zero fill
	input  logic [spom_pkg::S_TDATA_W-1:0]  s_tdata,
	// kind[1:0]
	input  logic [spom_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// result_id[15:0], hit[16], error[17], overflow_seen[18], zero fill
	output logic [spom_pkg::M_TDATA_W-1:0]  m_tdata,
	// result_kind[0]
	output logic [0:0]                      m_tuser
);

	localparam int IW = spom_pkg::ID_W;

	logic           f_vld;
	spom_pkg::cmd_t f_cmd;
	logic           q_not_full;
	logic           q_not_empty;
	spom_pkg::cmd_t q_cmd;
	logic           q_pop;
	spom_pkg::res_t res;

	spom_front #(
		.COORD_LIMIT(COORD_LIMIT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd_vld  (f_vld),
		.cmd      (f_cmd),
		.cmd_rdy  (q_not_full)
	);

	spom_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_vld),
		.push_data (f_cmd),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (q_cmd)
	);

	spom_back #(
		.ACTIVE_DEPTH(ACTIVE_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_vld   (q_not_empty),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.res_vld (m_tvalid),
		.res     (res),
		.res_rdy (m_tready)
	);

	assign m_tdata = {(spom_pkg::M_TDATA_W - IW - 3)'(0), res.overflow, res.error, res.hit, res.id};
	assign m_tuser = res.kind;

endmodule

FILE: tb/tb_sweep_prune_occlusion_marker_unit.sv
// self-checking testbench for sweep_prune_occlusion_marker_unit: directed edge cases, then
// randomized sweep scenes with stalls on both streams and one long output hold
// depends on spom_pkg and the rtl top level only
`timescale 1ns / 100ps

module tb_sweep_prune_occlusion_marker_unit;

	localparam int ID_W      = spom_pkg::ID_W;
	localparam int Y_W       = spom_pkg::Y_W;
	localparam int DEPTH_W   = spom_pkg::DEPTH_W;
	localparam int S_TDATA_W = spom_pkg::S_TDATA_W;
	localparam int S_TUSER_W = spom_pkg::S_TUSER_W;
	localparam int M_TDATA_W = spom_pkg::M_TDATA_W;

	localparam logic [1:0] KIND_UNUSED      = 2'd3;
	localparam logic       VERDICT_OCCLUDER = 1'b0;
	localparam logic       VERDICT_CASTER   = 1'b1;
	localparam int         Y_MAX            = (1 << Y_W) - 1;
	localparam logic [Y_W-1:0]     Y_TOP    = Y_W'(Y_MAX);
	localparam logic [Y_W-1:0]     Y_ZERO   = '0;
	localparam logic [DEPTH_W-1:0] Z_ZERO   = '0;
	localparam int         ITEMS_TOTAL      = 1150;
	localparam int         LONG_HOLD        = 400;
	localparam int         DRAIN_CYCLES     = 120;

	// shadow of the active set; predicts one verdict per caster point or right edge
	class verdict_board;
		logic [ID_W-1:0]           occ_id[spom_pkg::ACTIVE_DEPTH_DEF];
		logic [Y_W-1:0]            occ_top[spom_pkg::ACTIVE_DEPTH_DEF];
		logic [Y_W-1:0]            occ_bottom[spom_pkg::ACTIVE_DEPTH_DEF];
		logic signed [DEPTH_W-1:0] occ_depth[spom_pkg::ACTIVE_DEPTH_DEF];
		bit                        occ_marked[spom_pkg::ACTIVE_DEPTH_DEF];
		int                        live;
		bit                        overflow;
		spom_pkg::res_t            expected_verdicts[$];
		int                        mismatches;
		int                        checked;
		int                        points;
		int                        removals;

		function new();
			live = 0;
			overflow = 0;
			mismatches = 0;
			checked = 0;
			points = 0;
			removals = 0;
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		function void note_transaction(logic [S_TUSER_W-1:0] kind, logic [S_TDATA_W-1:0] data);
			logic [ID_W-1:0]           id;
			logic [Y_W-1:0]            cy;
			logic signed [DEPTH_W-1:0] z;
			spom_pkg::res_t            v;
			int                        i;
			int                        last;
			bit                        found;
			id = data[15:0];
			cy = data[57:44];
			z = data[81:58];
			v.kind = VERDICT_OCCLUDER;
			v.id = id;
			v.hit = 1'b0;
			v.error = 1'b0;
			case (kind)
				spom_pkg::KIND_EDGE_IN: begin
					// a full set drops the edge and latches overflow
					if (live >= spom_pkg::ACTIVE_DEPTH_DEF) begin
						overflow = 1'b1;
					end else begin
						occ_id[live] = id;
						occ_top[live] = data[29:16];
						occ_bottom[live] = data[43:30];
						occ_depth[live] = z;
						occ_marked[live] = 1'b0;
						live++;
					end
					return;
				end
				spom_pkg::KIND_EDGE_OUT: begin
					removals++;
					found = 1'b0;
					// highest matching index wins, last entry moves into the hole
					for (i = live - 1; i >= 0 && !found; i--) begin
						if (occ_id[i] == id) begin
							last = live - 1;
							v.hit = occ_marked[i];
							occ_id[i] = occ_id[last];
							occ_top[i] = occ_top[last];
							occ_bottom[i] = occ_bottom[last];
							occ_depth[i] = occ_depth[last];
							occ_marked[i] = occ_marked[last];
							live = last;
							found = 1'b1;
						end
					end
					v.error = !found;
				end
				spom_pkg::KIND_POINT: begin
					points++;
					v.kind = VERDICT_CASTER;
					for (i = 0; i < live; i++) begin
						if (cy >= occ_top[i] && cy <= occ_bottom[i] && z >= occ_depth[i]) begin
							occ_marked[i] = 1'b1;
							v.hit = 1'b1;
						end
					end
				end
				default: return;
			endcase
			v.overflow = overflow;
			expected_verdicts = {expected_verdicts, v};
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_verdict(logic [M_TDATA_W-1:0] data, logic [0:0] user);
			spom_pkg::res_t want;
			if (expected_verdicts.size() == 0) begin
				$error("result_id: expected none, got %0h", data[15:0]);
				mismatches++;
				return;
			end
			want = expected_verdicts.pop_front();
			checked++;
			compare_field("result_kind", want.kind, user[0]);
			compare_field("result_id", want.id, data[15:0]);
			compare_field("hit", want.hit, data[16]);
			compare_field("error", want.error, data[17]);
			compare_field("overflow_seen", want.overflow, data[18]);
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata = '0;
	logic [S_TUSER_W-1:0]   s_tuser = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [0:0]             m_tuser;

	verdict_board           board;
	logic [ID_W-1:0]        open_ids[$];
	int                     items_sent = 0;
	bit                     burst_mode = 1'b0;
	bit                     stall_request = 1'b0;

	sweep_prune_occlusion_marker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			board.note_transaction(s_tuser, s_tdata);
		end
		if (arst_n && m_tvalid && m_tready) begin
			board.check_verdict(m_tdata, m_tuser);
		end
	end

	function automatic logic [S_TDATA_W-1:0] field_pack(logic [ID_W-1:0] id,
			logic [Y_W-1:0] y_low, logic [Y_W-1:0] y_high, logic [Y_W-1:0] caster_y,
			logic [DEPTH_W-1:0] depth);
		return {6'b0, depth, caster_y, y_high, y_low, id};
	endfunction

	function automatic logic [Y_W-1:0] pick_y(int base, int span);
		int y;
		y = base + $urandom_range(0, span - 1);
		if (y > Y_MAX) begin
			y = Y_MAX;
		end
		return y[Y_W-1:0];
	endfunction

	// mostly values close together so ties and near misses happen
	function automatic logic [DEPTH_W-1:0] pick_depth();
		logic [31:0] r;
		int          d;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: return r[DEPTH_W-1:0];
			1: begin
				d = $urandom_range(0, 16) - 8;
				return d[DEPTH_W-1:0];
			end
			2: begin
				case (r[1:0])
					2'd0: return 24'h800000;
					2'd1: return 24'h7fffff;
					2'd2: return 24'h000000;
					default: return 24'hffffff;
				endcase
			end
			default: begin
				d = $urandom_range(0, 1 << 21) - (1 << 20);
				return d[DEPTH_W-1:0];
			end
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_id();
		logic [31:0] r;
		r = $urandom;
		// occasional reuse of a live id exercises duplicate removal
		if (open_ids.size() > 0 && $urandom_range(0, 9) == 0) begin
			return open_ids[$urandom_range(0, open_ids.size() - 1)];
		end
		return r[ID_W-1:0];
	endfunction

	task automatic send_item(logic [1:0] kind, logic [S_TDATA_W-1:0] data);
		int gap;
		s_tuser <= kind;
		s_tdata <= data;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		if (kind != KIND_UNUSED) begin
			items_sent++;
		end
		gap = burst_mode ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic open_edge(int base, int span);
		logic [ID_W-1:0] id;
		logic [Y_W-1:0]  a;
		logic [Y_W-1:0]  b;
		int              t;
		id = pick_id();
		a = pick_y(base, span);
		t = a + $urandom_range(0, span / 2);
		if (t > Y_MAX) begin
			t = Y_MAX;
		end
		b = t[Y_W-1:0];
		open_ids = {open_ids, id};
		if ($urandom_range(0, 7) == 0) begin
			send_item(spom_pkg::KIND_EDGE_IN,
				field_pack(id, b, a, pick_y(0, Y_MAX + 1), pick_depth()));
		end else begin
			send_item(spom_pkg::KIND_EDGE_IN,
				field_pack(id, a, b, pick_y(0, Y_MAX + 1), pick_depth()));
		end
	endtask

	task automatic close_edge();
		int              idx;
		logic [ID_W-1:0] id;
		idx = $urandom_range(0, open_ids.size() - 1);
		id = open_ids[idx];
		open_ids.delete(idx);
		send_item(spom_pkg::KIND_EDGE_OUT, field_pack(id, pick_y(0, Y_MAX + 1),
			pick_y(0, Y_MAX + 1), pick_y(0, Y_MAX + 1), pick_depth()));
	endtask

	task automatic send_caster(int base, int span);
		logic [31:0] r;
		r = $urandom;
		send_item(spom_pkg::KIND_POINT, field_pack(r[ID_W-1:0], pick_y(0, Y_MAX + 1),
			pick_y(0, Y_MAX + 1), pick_y(base, span), pick_depth()));
	endtask

	// one sweep across a y window: edges and casters interleaved, every occluder closed at the end
	task automatic run_scene(int n, int cap, int span);
		int          base;
		int          k;
		int          r;
		logic [31:0] junk[3];
		base = $urandom_range(0, Y_MAX + 1 - span);
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 99);
			if (r < 35 && open_ids.size() < cap) begin
				open_edge(base, span);
			end else if (r < 55 && open_ids.size() > 0) begin
				close_edge();
			end else if (r < 60) begin
				junk[0] = $urandom;
				junk[1] = $urandom;
				junk[2] = $urandom;
				if (junk[0][31]) begin
					send_item(spom_pkg::KIND_EDGE_OUT, {junk[2][23:0], junk[1], junk[0]});
				end else begin
					send_item(KIND_UNUSED, {junk[2][23:0], junk[1], junk[0]});
				end
			end else begin
				send_caster(base, span);
			end
		end
		while (open_ids.size() > 0) begin
			close_edge();
		end
	endtask

	// pushes the set past full, so overflow latches and dropped edges come back as unknown
	task automatic fill_scene();
		int k;
		for (k = 0; k < spom_pkg::ACTIVE_DEPTH_DEF + 2; k++) begin
			open_edge(0, 64);
		end
		for (k = 0; k < 10; k++) begin
			send_caster(0, 64);
		end
		while (open_ids.size() > 0) begin
			close_edge();
		end
	endtask

	task automatic directed_items();
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h1234, Y_ZERO, Y_ZERO, Y_ZERO, 24'h800000));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'hffff, Y_ZERO, Y_ZERO, Y_ZERO, Z_ZERO));
		send_item(spom_pkg::KIND_EDGE_IN,
			field_pack(16'h0000, Y_ZERO, Y_TOP, Y_ZERO, 24'h7fffff));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'hffff, Y_ZERO, Y_ZERO, Y_TOP, 24'h7fffff));
		// single-row occluder
		send_item(spom_pkg::KIND_EDGE_IN,
			field_pack(16'h0001, Y_W'(100), Y_W'(100), Y_ZERO, 24'h000000));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h0010, Y_ZERO, Y_ZERO, Y_W'(99), 24'h000000));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h0011, Y_ZERO, Y_ZERO, Y_W'(100), 24'hffffff));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h0012, Y_ZERO, Y_ZERO, Y_W'(100), 24'h000000));
		// inverted range never contains a caster
		send_item(spom_pkg::KIND_EDGE_IN,
			field_pack(16'h0002, Y_W'(200), Y_W'(150), Y_ZERO, 24'h800000));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h0013, Y_ZERO, Y_ZERO, Y_W'(175), 24'h7fffff));
		// duplicate id: newest entry goes first
		send_item(spom_pkg::KIND_EDGE_IN,
			field_pack(16'h0001, Y_ZERO, Y_W'(10), Y_ZERO, 24'h000000));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'h0001, Y_ZERO, Y_ZERO, Y_ZERO, Z_ZERO));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'h0001, Y_ZERO, Y_ZERO, Y_ZERO, Z_ZERO));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'h0002, Y_ZERO, Y_ZERO, Y_ZERO, Z_ZERO));
		send_item(KIND_UNUSED, field_pack(16'hffff, Y_TOP, Y_TOP, Y_TOP, 24'hffffff));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'h0000, Y_ZERO, Y_ZERO, Y_ZERO, Z_ZERO));
		send_item(spom_pkg::KIND_EDGE_IN,
			field_pack(16'hffff, Y_TOP, Y_TOP, Y_TOP, 24'hffffff));
		send_item(spom_pkg::KIND_POINT,
			field_pack(16'h0000, Y_ZERO, Y_ZERO, Y_TOP, 24'h000000));
		send_item(spom_pkg::KIND_EDGE_OUT,
			field_pack(16'hffff, Y_TOP, Y_TOP, Y_TOP, 24'hffffff));
	endtask

	// output side: per-transaction stall, plus one long hold on request
	initial begin
		int hold;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_request) begin
				hold = LONG_HOLD;
			end else begin
				hold = burst_mode ? 0 : $urandom_range(0, 3);
			end
			if (hold > 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			stall_request = 1'b0;
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		#5_000_000;
		$display("** sweep_prune_occlusion_marker_unit: FAILED **");
		$finish;
	end

	initial begin
		bit did_stall;
		bit did_fill;
		int span;
		board = new();
		did_stall = 1'b0;
		did_fill = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_items();
		while (items_sent < ITEMS_TOTAL) begin
			burst_mode = ($urandom_range(0, 4) == 0);
			if (!did_stall && items_sent > 300) begin
				// keep offering while the output is held so the command queue backs up
				burst_mode = 1'b1;
				stall_request = 1'b1;
				did_stall = 1'b1;
			end
			case ($urandom_range(0, 3))
				0: span = 8;
				1: span = 64;
				2: span = 1024;
				default: span = Y_MAX + 1;
			endcase
			if (!did_fill && items_sent > 750) begin
				fill_scene();
				did_fill = 1'b1;
			end else begin
				run_scene($urandom_range(4, 40), ($urandom_range(0, 5) == 0) ? 48 : 8, span);
			end
		end
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transactions: %0d caster points, %0d right edges, %0d verdicts",
			items_sent, board.points, board.removals, board.checked);
		$display("active-set overflow reached: %0d, mismatches: %0d", board.overflow,
			board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("** sweep_prune_occlusion_marker_unit: PASSED **");
		end else begin
			$display("** sweep_prune_occlusion_marker_unit: FAILED **");
		end
		$finish;
	end

endmodule
